// ----- design/ises_pkg.sv -----
package ises_pkg;

  localparam int KeyW = 8;

  // Command codes of one request
  typedef enum logic [2:0] {
    CmdInsert = 3'd0,
    CmdDelete = 3'd1,
    CmdSucc   = 3'd2,
    CmdMember = 3'd3,
    CmdMin    = 3'd4,
    CmdMax    = 3'd5
  } cmd_e;

  // Result source chosen by the controller
  typedef enum logic [2:0] {
    ResNone   = 3'd0,
    ResMember = 3'd1,
    ResLocal  = 3'd2,
    ResNext   = 3'd3,
    ResMin    = 3'd4,
    ResMax    = 3'd5
  } res_sel_e;

  typedef struct packed {
    logic [2:0]      cmd;
    logic [KeyW-1:0] key;
  } req_t;

  typedef struct packed {
    logic [KeyW-1:0] value;
    logic            found;
  } res_t;

  // Controller to datapath
  typedef struct packed {
    logic     load;
    logic     ins_commit;
    logic     del_commit;
    logic     rd_succ;
    logic     rd_min;
    logic     cap_min;
    logic     cap_max;
    logic     resp;
    res_sel_e res_sel;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [2:0] cmd;
    logic       in_range;
    logic       bit_set;
    logic       succ_local;
    logic       succ_next;
    logic       bound_hit;
    logic       sum_empty;
  } dp_sts_t;

endpackage

// ----- design/ises_ram.sv -----
module ises_ram #(
  parameter int Width = 16,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  // Write one row, read one row with registered data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ----- design/ises_dp.sv -----
module ises_dp #(
  parameter int Universe = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ises_pkg::req_t   req_i,
  input  ises_pkg::dp_cmd_t cmd_i,
  output ises_pkg::dp_sts_t sts_o,
  output ises_pkg::res_t   res_o
);

  localparam int LogU    = $clog2(Universe + 1) - 1;
  localparam int LowRaw  = LogU / 2;
  localparam int LowW    = (LowRaw > 4) ? 4 : LowRaw;
  localparam int NumKeys = (Universe > 256) ? 256 : Universe;
  localparam int CW      = 1 << LowW;
  localparam int NC      = (NumKeys + CW - 1) / CW;
  localparam int HighW   = $clog2(NC);
  localparam int KeyW    = ises_pkg::KeyW;

  function automatic logic [LowW-1:0] row_lo(logic [CW-1:0] v);
    logic [LowW-1:0] r;
    r = '0;
    for (int i = CW - 1; i >= 0; i--) begin
      if (v[i]) r = LowW'(i);
    end
    return r;
  endfunction

  function automatic logic [LowW-1:0] row_hi(logic [CW-1:0] v);
    logic [LowW-1:0] r;
    r = '0;
    for (int i = 0; i < CW; i++) begin
      if (v[i]) r = LowW'(i);
    end
    return r;
  endfunction

  function automatic logic [HighW-1:0] sum_lo(logic [NC-1:0] v);
    logic [HighW-1:0] r;
    r = '0;
    for (int i = NC - 1; i >= 0; i--) begin
      if (v[i]) r = HighW'(i);
    end
    return r;
  endfunction

  function automatic logic [HighW-1:0] sum_hi(logic [NC-1:0] v);
    logic [HighW-1:0] r;
    r = '0;
    for (int i = 0; i < NC; i++) begin
      if (v[i]) r = HighW'(i);
    end
    return r;
  endfunction

  function automatic logic [KeyW-1:0] join_key(logic [HighW-1:0] hi, logic [LowW-1:0] lo);
    return KeyW'((32'(hi) << LowW) | 32'(lo));
  endfunction

  ises_pkg::req_t   req_q;
  logic [HighW-1:0] rd_addr_q, rd_addr_d;
  logic [NC-1:0]    summary_q;
  logic [NC-1:0]    valid_q;
  logic             empty_q;
  logic [KeyW-1:0]  min_q, max_q;
  ises_pkg::res_t   res_q, res_d;

  logic             req_in_range, key_in_range;
  logic [HighW-1:0] hi_q;
  logic [LowW-1:0]  lo_q;
  logic [CW-1:0]    ram_rdata, row, onehot, local_mask, local_bits;
  logic [NC-1:0]    above_mask, above_bits;
  logic [CW-1:0]    wdata;
  logic             we, re;

  // Split the held key into cluster and position
  assign req_in_range = int'(req_i.key) < NumKeys;
  assign key_in_range = int'(req_q.key) < NumKeys;
  assign hi_q         = key_in_range ? HighW'(req_q.key >> LowW) : '0;
  assign lo_q         = LowW'(req_q.key);
  assign onehot       = CW'(1) << lo_q;

  // Mask rows never written to zero
  assign row        = valid_q[rd_addr_q] ? ram_rdata : '0;
  assign local_mask = ({CW{1'b1}} << lo_q) << 1;
  assign local_bits = row & local_mask;
  assign above_mask = ({NC{1'b1}} << hi_q) << 1;
  assign above_bits = summary_q & above_mask;

  // Select the row to read
  assign re = cmd_i.load | cmd_i.rd_succ | cmd_i.rd_min | cmd_i.cap_min;
  always_comb begin
    if (cmd_i.load) begin
      rd_addr_d = req_in_range ? HighW'(req_i.key >> LowW) : '0;
    end else if (cmd_i.rd_succ) begin
      rd_addr_d = sum_lo(above_bits);
    end else if (cmd_i.rd_min) begin
      rd_addr_d = sum_lo(summary_q);
    end else begin
      rd_addr_d = sum_hi(summary_q);
    end
  end

  // Set or clear the key's bit in its row
  assign we    = cmd_i.ins_commit | cmd_i.del_commit;
  assign wdata = cmd_i.ins_commit ? (row | onehot) : (row & ~onehot);

  ises_ram #(
    .Width(CW),
    .Depth(NC)
  ) u_rows (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(hi_q),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(rd_addr_d),
    .rdata_o(ram_rdata)
  );

  // Hold the request, the read address and the result
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
    if (re) begin
      rd_addr_q <= rd_addr_d;
    end
    if (cmd_i.resp) begin
      res_q <= res_d;
    end
  end

  // Update summary, row valid bits, empty flag and bounds
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      summary_q <= '0;
      valid_q   <= '0;
      empty_q   <= 1'b1;
      min_q     <= '0;
      max_q     <= '0;
    end else begin
      if (we) begin
        valid_q[hi_q] <= 1'b1;
      end
      if (cmd_i.ins_commit) begin
        summary_q[hi_q] <= 1'b1;
        empty_q         <= 1'b0;
        if (empty_q || req_q.key < min_q) min_q <= req_q.key;
        if (empty_q || req_q.key > max_q) max_q <= req_q.key;
      end
      if (cmd_i.del_commit) begin
        summary_q[hi_q] <= |(row & ~onehot);
      end
      if (cmd_i.rd_min && summary_q == '0) begin
        empty_q <= 1'b1;
        min_q   <= '0;
        max_q   <= '0;
      end
      if (cmd_i.cap_min) begin
        min_q <= join_key(rd_addr_q, row_lo(row));
      end
      if (cmd_i.cap_max) begin
        max_q <= join_key(rd_addr_q, row_hi(row));
      end
    end
  end

  // Form the result
  always_comb begin
    res_d = '0;
    case (cmd_i.res_sel)
      ises_pkg::ResMember: res_d.found = key_in_range & |(row & onehot);
      ises_pkg::ResLocal: begin
        res_d.value = join_key(hi_q, row_lo(local_bits));
        res_d.found = 1'b1;
      end
      ises_pkg::ResNext: begin
        res_d.value = join_key(rd_addr_q, row_lo(row));
        res_d.found = 1'b1;
      end
      ises_pkg::ResMin: begin
        res_d.value = empty_q ? '0 : min_q;
        res_d.found = ~empty_q;
      end
      ises_pkg::ResMax: begin
        res_d.value = empty_q ? '0 : max_q;
        res_d.found = ~empty_q;
      end
      default: res_d = '0;
    endcase
  end

  assign res_o = res_q;

  // Report status to the controller
  assign sts_o.cmd        = req_q.cmd;
  assign sts_o.in_range   = key_in_range;
  assign sts_o.bit_set    = |(row & onehot);
  assign sts_o.succ_local = |local_bits;
  assign sts_o.succ_next  = |above_bits;
  assign sts_o.bound_hit  = (req_q.key == min_q) || (req_q.key == max_q);
  assign sts_o.sum_empty  = (summary_q == '0);

endmodule

// ----- design/ises_ctrl.sv -----
module ises_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  output logic              res_valid_o,
  input  ises_pkg::dp_sts_t sts_i,
  output ises_pkg::dp_cmd_t cmd_o
);

  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StEval  = 6'b000010,
    StSucc  = 6'b000100,
    StMinRd = 6'b001000,
    StMinEv = 6'b010000,
    StMaxEv = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   done_q;

  // Sequence one request
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = StEval;
        end
      end
      StEval: begin
        cmd_o.resp = 1'b1;
        state_d    = StIdle;
        case (sts_i.cmd)
          ises_pkg::CmdInsert: begin
            cmd_o.ins_commit = sts_i.in_range & ~sts_i.bit_set;
          end
          ises_pkg::CmdDelete: begin
            if (sts_i.in_range && sts_i.bit_set) begin
              cmd_o.del_commit = 1'b1;
              if (sts_i.bound_hit) begin
                cmd_o.resp = 1'b0;
                state_d    = StMinRd;
              end
            end
          end
          ises_pkg::CmdSucc: begin
            if (sts_i.in_range && sts_i.succ_local) begin
              cmd_o.res_sel = ises_pkg::ResLocal;
            end else if (sts_i.in_range && sts_i.succ_next) begin
              cmd_o.rd_succ = 1'b1;
              cmd_o.resp    = 1'b0;
              state_d       = StSucc;
            end
          end
          ises_pkg::CmdMember: cmd_o.res_sel = ises_pkg::ResMember;
          ises_pkg::CmdMin:    cmd_o.res_sel = ises_pkg::ResMin;
          ises_pkg::CmdMax:    cmd_o.res_sel = ises_pkg::ResMax;
          default:             cmd_o.res_sel = ises_pkg::ResNone;
        endcase
      end
      StSucc: begin
        cmd_o.resp    = 1'b1;
        cmd_o.res_sel = ises_pkg::ResNext;
        state_d       = StIdle;
      end
      StMinRd: begin
        cmd_o.rd_min = 1'b1;
        if (sts_i.sum_empty) begin
          cmd_o.resp = 1'b1;
          state_d    = StIdle;
        end else begin
          state_d = StMinEv;
        end
      end
      StMinEv: begin
        cmd_o.cap_min = 1'b1;
        state_d       = StMaxEv;
      end
      StMaxEv: begin
        cmd_o.cap_max = 1'b1;
        cmd_o.resp    = 1'b1;
        state_d       = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= cmd_o.resp;
    end
  end

  assign busy        = (state_q != StIdle);
  assign res_valid_o = done_q;

endmodule

// ----- design/integer_set_successor_engine.sv -----
// Integer set over keys 0 .. UNIVERSE-1, at most 0 .. 255, kept as per-cluster bitmaps in a
// RAM with one write and one read port, plus a summary bitmap, minimum and
// maximum in flip-flops.
// A request is taken when start is high and busy is low; its one result is
// shown for exactly one cycle with res_valid_o and cannot be held off.
// Membership, insert, minimum, maximum, an unused command, a delete that
// keeps both bounds and a successor found in the key's own cluster or not
// at all end after StEval; a successor in a later cluster adds StSucc, and
// a delete of the current minimum or maximum adds StMinRd, StMinEv and
// StMaxEv (only StMinRd if it empties the set), as the one read port of
// the cluster RAM serves one row per cycle. The next request may start in
// the cycle its predecessor's result is shown. Reset clears the set at
// once through per-row valid bits; no clearing pass is run.
module integer_set_successor_engine #(
  parameter int UNIVERSE = 256
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  ises_pkg::req_t req_i,
  output logic           res_valid_o,
  output ises_pkg::res_t res_o
);

  ises_pkg::dp_cmd_t dp_cmd;
  ises_pkg::dp_sts_t dp_sts;

  ises_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .res_valid_o(res_valid_o),
    .sts_i      (dp_sts),
    .cmd_o      (dp_cmd)
  );

  ises_dp #(
    .Universe(UNIVERSE)
  ) u_dp (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_i),
    .cmd_i (dp_cmd),
    .sts_o (dp_sts),
    .res_o (res_o)
  );

`ifndef SYNTHESIS
  // A result only follows work done while busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(busy))
    else $error("result without a request in progress");

  // A result is shown only once the controller is back to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !busy)
    else $error("result shown while busy");

  // An accepted request always occupies the block for the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !res_valid_o))
    else $error("accepted request not taken up");
`endif

endmodule

// ----- bench/ises_checker.sv -----
module ises_checker
  import ises_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic busy_i,
  input  req_t req_i,
  input  logic res_valid_i,
  input  res_t res_i,
  output int   errors_o,
  output int   outstanding_o,
  output int   checked_o,
  output int   hits_o
);

  // One accepted request with the answer it must produce
  typedef struct packed {
    req_t req;
    res_t want;
  } due_t;

  due_t due_q[$];
  due_t head;

  // Shadow of the set: membership rows, non-empty clusters, bounds
  logic [15:0] row_q [16];
  logic [15:0] occupied_q;
  logic [7:0]  lowest_q;
  logic [7:0]  highest_q;
  logic        void_q;

  int fault_cnt = 0;
  int compared_cnt = 0;
  int hit_cnt = 0;

  assign errors_o  = fault_cnt;
  assign checked_o = compared_cnt;
  assign hits_o    = hit_cnt;

  task automatic flag_fault(input string what);
    fault_cnt++;
    if (fault_cnt <= 10) $display("%s", what);
  endtask

  // Recompute minimum, maximum and the empty flag from the rows
  function automatic void rescan_bounds();
    bit got;
    got = 1'b0;
    lowest_q  = '0;
    highest_q = '0;
    for (int c = 0; c < 16; c++) begin
      for (int k = 0; k < 16; k++) begin
        if (occupied_q[c] && row_q[c][k]) begin
          if (!got) lowest_q = 8'(c * 16 + k);
          highest_q = 8'(c * 16 + k);
          got = 1'b1;
        end
      end
    end
    void_q = !got;
  endfunction

  // Smallest member strictly above key: own cluster first, then later ones
  function automatic res_t successor(input logic [7:0] key);
    res_t ans;
    logic [3:0] hc;
    ans = '0;
    hc  = key[7:4];
    for (int k = int'(key[3:0]) + 1; k < 16; k++) begin
      if (row_q[hc][k]) begin
        ans.value = {hc, 4'(k)};
        ans.found = 1'b1;
        return ans;
      end
    end
    for (int c = int'(hc) + 1; c < 16; c++) begin
      if (occupied_q[c]) begin
        for (int k = 0; k < 16; k++) begin
          if (row_q[c][k]) begin
            ans.value = {4'(c), 4'(k)};
            ans.found = 1'b1;
            return ans;
          end
        end
      end
    end
    return ans;
  endfunction

  // Apply one request to the shadow and return its answer
  function automatic res_t apply_request(input req_t r);
    res_t ans;
    logic [3:0] hc;
    logic [3:0] lc;
    ans = '0;
    hc  = r.key[7:4];
    lc  = r.key[3:0];
    case (r.cmd)
      CmdInsert: begin
        if (!row_q[hc][lc]) begin
          row_q[hc][lc]  = 1'b1;
          occupied_q[hc] = 1'b1;
          rescan_bounds();
        end
      end
      CmdDelete: begin
        if (row_q[hc][lc]) begin
          row_q[hc][lc]  = 1'b0;
          occupied_q[hc] = |row_q[hc];
          rescan_bounds();
        end
      end
      CmdSucc:   ans = successor(r.key);
      CmdMember: ans.found = row_q[hc][lc];
      CmdMin: begin
        if (!void_q) begin
          ans.value = lowest_q;
          ans.found = 1'b1;
        end
      end
      CmdMax: begin
        if (!void_q) begin
          ans.value = highest_q;
          ans.found = 1'b1;
        end
      end
      default: ans = '0;
    endcase
    return ans;
  endfunction

  // Compare each result with the oldest answer, then log the new request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < 16; c++) row_q[c] = '0;
      occupied_q = '0;
      lowest_q   = '0;
      highest_q  = '0;
      void_q     = 1'b1;
      due_q.delete();
      outstanding_o <= 0;
    end else begin
      if (res_valid_i) begin
        if (due_q.size() == 0) begin
          flag_fault($sformatf("unexpected result: value %0d found %0b",
                               res_i.value, res_i.found));
        end else begin
          head = due_q.pop_front();
          compared_cnt++;
          if (head.want.found) hit_cnt++;
          if (res_i.value !== head.want.value || res_i.found !== head.want.found) begin
            flag_fault($sformatf(
              "mismatch cmd %0d key %0d: expected value %0d found %0b, got value %0d found %0b",
              head.req.cmd, head.req.key, head.want.value, head.want.found,
              res_i.value, res_i.found));
          end
        end
      end
      if (start_i && !busy_i) begin
        head.req  = req_i;
        head.want = apply_request(req_i);
        due_q     = {due_q, head};
      end
      outstanding_o <= due_q.size();
    end
  end

endmodule

// ----- bench/testbench.sv -----
module testbench;

  import ises_pkg::*;

  // Command codes outside the defined set
  localparam logic [2:0] CmdSpareLo = 3'd6;
  localparam logic [2:0] CmdSpareHi = 3'd7;

  localparam int CycleLimit = 300000;
  localparam int PhaseItems = 140;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req_i;
  logic res_valid_o;
  res_t res_o;

  int errors;
  int outstanding;
  int checked;
  int hits;
  int cycle_q = 0;
  int idle_pct;
  int sent;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  integer_set_successor_engine i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  ises_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_i        (busy),
    .req_i         (req_i),
    .res_valid_i   (res_valid_o),
    .res_i         (res_o),
    .errors_o      (errors),
    .outstanding_o (outstanding),
    .checked_o     (checked),
    .hits_o        (hits)
  );

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_q <= cycle_q + 1;
    if (cycle_q == CycleLimit) begin
      $display("integer_set_successor_engine verification failed");
      $finish;
    end
  end

  // Offer one request after a random gap and hold it until taken
  task automatic issue(input logic [2:0] cmd, input logic [7:0] key);
    int gap;
    req_t r;
    gap = 0;
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) gap++;
    r.cmd = cmd;
    r.key = key;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sent++;
  endtask

  // Hold off until every outstanding request has answered
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  // Random requests with keys drawn from a window; grow favours inserts
  task automatic run_phase(input int pct, input int span, input bit grow);
    logic [7:0] base;
    logic [2:0] cmd;
    int roll;
    idle_pct = pct;
    base = 8'($urandom);
    for (int n = 0; n < PhaseItems; n++) begin
      roll = $urandom_range(99);
      if (roll < (grow ? 40 : 20)) cmd = CmdInsert;
      else if (roll < 55) cmd = CmdDelete;
      else if (roll < 75) cmd = CmdSucc;
      else if (roll < 86) cmd = CmdMember;
      else if (roll < 92) cmd = CmdMin;
      else if (roll < 98) cmd = CmdMax;
      else cmd = roll[0] ? CmdSpareHi : CmdSpareLo;
      issue(cmd, base + 8'($urandom_range(span - 1)));
    end
    settle();
  endtask

  initial begin
    rst_ni   = 1'b0;
    start    = 1'b0;
    req_i    = '0;
    idle_pct = 0;
    sent     = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty set, key extremes, cluster edges, duplicates, bound removal
    issue(CmdMember, 8'd0);
    issue(CmdMin,    8'd0);
    issue(CmdMax,    8'd255);
    issue(CmdSucc,   8'd0);
    issue(CmdInsert, 8'd0);
    issue(CmdInsert, 8'd255);
    issue(CmdInsert, 8'd0);
    issue(CmdDelete, 8'd17);
    issue(CmdMin,    8'd0);
    issue(CmdMax,    8'd0);
    issue(CmdSucc,   8'd0);
    issue(CmdSucc,   8'd255);
    issue(CmdInsert, 8'd16);
    issue(CmdInsert, 8'd15);
    issue(CmdSucc,   8'd14);
    issue(CmdSucc,   8'd15);
    issue(CmdDelete, 8'd0);
    issue(CmdMin,    8'd0);
    issue(CmdDelete, 8'd255);
    issue(CmdMax,    8'd0);
    issue(CmdMember, 8'd16);
    issue(CmdSpareLo, 8'd16);
    issue(CmdSpareHi, 8'd15);
    issue(CmdDelete, 8'd16);
    issue(CmdDelete, 8'd15);
    issue(CmdMin,    8'd0);
    issue(CmdMax,    8'd0);
    settle();

    run_phase(0,  256, 1'b1);
    run_phase(49, 24,  1'b1);
    run_phase(13, 40,  1'b0);
    run_phase(0,  20,  1'b0);
    run_phase(49, 256, 1'b1);
    run_phase(13, 16,  1'b0);

    repeat (8) @(posedge clk_i);
    $display("Covered %0d requests: corner keys, then six random phases", sent);
    $display("Sender gaps 0/13/49 percent; %0d results compared, %0d with found set",
             checked, hits);
    if (errors == 0 && outstanding == 0) begin
      $display("integer_set_successor_engine verification clean");
    end else begin
      $display("integer_set_successor_engine verification failed");
    end
    $finish;
  end

endmodule
